### sv/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CMSP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cmsp assertion failed");

// Antecedent implies consequent in the following cycle.
`define CMSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cmsp assertion failed");

`endif

### sv/cmsp_pkg.sv
// Types and constants shared by the CoAP message stream parser.
package cmsp_pkg;

    localparam int unsigned CMSP_FIFO_DEPTH = 4;
    localparam int unsigned S_TDATA_W       = 8;
    localparam int unsigned M_TDATA_W       = 72;
    localparam int unsigned M_TUSER_W       = 3;

    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_TOKEN    = 3'd1,
        EV_OPTION   = 3'd2,
        EV_OPT_BYTE = 3'd3,
        EV_PAYLOAD  = 3'd4,
        EV_COMPLETE = 3'd5,
        EV_ERROR    = 3'd6
    } event_kind_t;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_TOKEN     = 7'b0000010,
        PH_OPTHDR    = 7'b0000100,
        PH_DELTA_EXT = 7'b0001000,
        PH_LEN_EXT   = 7'b0010000,
        PH_VALUE     = 7'b0100000,
        PH_PAYLOAD   = 7'b1000000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] header_shift;
        logic [1:0]  header_count;
        logic [3:0]  token_left;
        logic [15:0] option_sum;
        logic [15:0] delta_work;
        logic [15:0] length_work;
        logic [1:0]  ext_left;
        logic [15:0] value_left;
        logic        discarding;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:        PH_IDLE,
        header_shift: 32'h0,
        header_count: 2'd0,
        token_left:   4'd0,
        option_sum:   16'h0,
        delta_work:   16'h0,
        length_work:  16'h0,
        ext_left:     2'd0,
        value_left:   16'h0,
        discarding:   1'b0
    };

    typedef struct packed {
        event_kind_t kind;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] message_id;
        logic [3:0]  token_length;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  out_byte;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } result_pair_t;

endpackage

### sv/cmsp_decoder.sv
// Per-byte decode: next parser state and up to two result items for one byte.
module cmsp_decoder (
    input  cmsp_pkg::parse_state_t cur,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output cmsp_pkg::parse_state_t nxt,
    output cmsp_pkg::result_pair_t pair
);
    import cmsp_pkg::*;

    function automatic logic type_code_ok(input logic [1:0] t, input logic [7:0] c);
        case (c) inside
            8'd0:                    return (t == 2'd2) || (t == 2'd3);
            [8'd1:8'd4]:             return (t == 2'd0) || (t == 2'd1);
            [8'd65:8'd69], [8'd128:8'd134], 8'd140, 8'd141, 8'd143, [8'd160:8'd165]:
                                     return t != 2'd3;
            default:                 return 1'b0;
        endcase
    endfunction

    function automatic logic option_ok(input logic [15:0] num, input logic [15:0] delta,
                                       input logic [15:0] len);
        logic rep;
        rep = (delta == 16'h0);
        if (num > 16'd255) begin
            return 1'b1;
        end
        case (num[7:0]) inside
            8'd5:                  return (len == 16'h0) && !rep;
            8'd4:                  return (len != 16'h0) && (len <= 16'd8);
            8'd1:                  return len <= 16'd8;
            8'd7, 8'd12, 8'd17:    return (len <= 16'd2) && !rep;
            8'd6:                  return (len <= 16'd3) && !rep;
            8'd14, 8'd60:          return (len <= 16'd4) && !rep;
            8'd3, 8'd39:           return (len != 16'h0) && (len <= 16'd255) && !rep;
            8'd8, 8'd11, 8'd15, 8'd20: return len <= 16'd255;
            8'd35:                 return (len != 16'h0) && (len <= 16'd1034) && !rep;
            default:               return 1'b0;
        endcase
    endfunction

    logic        do_start;
    logic        do_finish;
    logic        term_fail;
    logic        term_done;
    logic        e_valid;
    event_kind_t e_kind;
    logic [15:0] e_num;
    logic [15:0] e_len;
    logic [7:0]  e_byte;
    logic [15:0] ext_b;
    logic [15:0] num;
    logic [31:0] hs;
    logic [31:0] hs_eff;
    logic        hdr_good;
    logic        hdr_valid;
    logic        has_term;
    result_t     base;
    result_t     emit_res;
    result_t     term_res;

    always_comb begin
        nxt       = cur;
        do_start  = 1'b0;
        do_finish = 1'b0;
        term_fail = 1'b0;
        term_done = 1'b0;
        e_valid   = 1'b0;
        e_kind    = EV_HEADER;
        e_num     = 16'h0;
        e_len     = 16'h0;
        e_byte    = 8'h0;
        hdr_good  = 1'b0;
        num       = 16'h0;
        ext_b     = (cur.ext_left == 2'd2) ? {data_byte, 8'h00} : {8'h00, data_byte};
        hs        = {cur.header_shift[23:0], data_byte};

        if (cur.discarding) begin
            if (last_byte) begin
                nxt = PARSE_STATE_RESET;
            end
        end else begin
            unique case (cur.phase)
                PH_IDLE: begin
                    nxt.header_shift = hs;
                    if (cur.header_count != 2'd3) begin
                        nxt.header_count = cur.header_count + 2'd1;
                        term_fail        = last_byte;
                    end else begin
                        nxt.header_count = 2'd0;
                        if ((hs[31:30] != 2'b01) || !type_code_ok(hs[29:28], hs[23:16]) ||
                            (hs[27:24] > 4'd8)) begin
                            term_fail = 1'b1;
                        end else begin
                            hdr_good       = 1'b1;
                            nxt.token_left = hs[27:24];
                            nxt.option_sum = 16'h0;
                            nxt.phase      = (hs[27:24] != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                            e_valid        = 1'b1;
                            e_kind         = EV_HEADER;
                            if (last_byte) begin
                                if (hs[27:24] != 4'd0) begin
                                    term_fail = 1'b1;
                                end else begin
                                    term_done = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_TOKEN: begin
                    e_valid        = 1'b1;
                    e_kind         = EV_TOKEN;
                    e_byte         = data_byte;
                    nxt.token_left = cur.token_left - 4'd1;
                    if (nxt.token_left == 4'd0) begin
                        nxt.phase = PH_OPTHDR;
                        term_done = last_byte;
                    end else begin
                        term_fail = last_byte;
                    end
                end
                PH_OPTHDR: begin
                    if (data_byte == 8'hFF) begin
                        nxt.phase = PH_PAYLOAD;
                        term_done = last_byte;
                    end else if (data_byte[7:4] == 4'hF) begin
                        term_fail = 1'b1;
                    end else begin
                        nxt.length_work = {12'h0, data_byte[3:0]};
                        if (data_byte[7:4] < 4'd13) begin
                            nxt.delta_work = {12'h0, data_byte[7:4]};
                            do_start       = 1'b1;
                        end else begin
                            nxt.delta_work = (data_byte[7:4] == 4'd13) ? 16'd13 : 16'd269;
                            nxt.ext_left   = (data_byte[7:4] == 4'd13) ? 2'd1 : 2'd2;
                            nxt.phase      = PH_DELTA_EXT;
                            term_fail      = last_byte;
                        end
                    end
                end
                PH_DELTA_EXT: begin
                    nxt.delta_work = cur.delta_work + ext_b;
                    nxt.ext_left   = cur.ext_left - 2'd1;
                    if (nxt.ext_left == 2'd0) begin
                        do_start = 1'b1;
                    end else begin
                        term_fail = last_byte;
                    end
                end
                PH_LEN_EXT: begin
                    nxt.length_work = cur.length_work + ext_b;
                    nxt.ext_left    = cur.ext_left - 2'd1;
                    if (nxt.ext_left == 2'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        term_fail = last_byte;
                    end
                end
                PH_VALUE: begin
                    e_valid        = 1'b1;
                    e_kind         = EV_OPT_BYTE;
                    e_num          = cur.option_sum;
                    e_len          = cur.length_work;
                    e_byte         = data_byte;
                    nxt.value_left = cur.value_left - 16'd1;
                    if (nxt.value_left == 16'h0) begin
                        nxt.phase = PH_OPTHDR;
                        term_done = last_byte;
                    end else begin
                        term_fail = last_byte;
                    end
                end
                PH_PAYLOAD: begin
                    e_valid   = 1'b1;
                    e_kind    = EV_PAYLOAD;
                    e_byte    = data_byte;
                    term_done = last_byte;
                end
                default: begin
                    term_fail = 1'b1;
                end
            endcase

            if (do_start) begin
                if (nxt.length_work[3:0] < 4'd13) begin
                    nxt.length_work = {12'h0, nxt.length_work[3:0]};
                    do_finish       = 1'b1;
                end else if (nxt.length_work[3:0] == 4'hF) begin
                    term_fail = 1'b1;
                end else begin
                    nxt.ext_left    = (nxt.length_work[3:0] == 4'd13) ? 2'd1 : 2'd2;
                    nxt.length_work = (nxt.length_work[3:0] == 4'd13) ? 16'd13 : 16'd269;
                    nxt.phase       = PH_LEN_EXT;
                    term_fail       = last_byte;
                end
            end

            if (do_finish) begin
                num = nxt.option_sum + nxt.delta_work;
                if (!option_ok(num, nxt.delta_work, nxt.length_work)) begin
                    term_fail = 1'b1;
                end else begin
                    nxt.option_sum = num;
                    e_valid        = 1'b1;
                    e_kind         = EV_OPTION;
                    e_num          = num;
                    e_len          = nxt.length_work;
                    if (nxt.length_work == 16'h0) begin
                        nxt.phase = PH_OPTHDR;
                        term_done = last_byte;
                    end else begin
                        nxt.value_left = nxt.length_work;
                        nxt.phase      = PH_VALUE;
                        term_fail      = last_byte;
                    end
                end
            end

            if (term_fail || term_done) begin
                nxt            = PARSE_STATE_RESET;
                nxt.discarding = term_fail && !last_byte;
            end
        end
    end

    // Header fields are reported once a header has been accepted, zero before that.
    assign hdr_valid = (cur.phase != PH_IDLE) || hdr_good;
    assign hs_eff    = (cur.phase == PH_IDLE) ? hs : cur.header_shift;
    assign has_term  = term_fail || term_done;

    always_comb begin
        base               = '0;
        base.kind          = EV_HEADER;
        base.msg_type      = hdr_valid ? hs_eff[29:28] : 2'd0;
        base.msg_code      = hdr_valid ? hs_eff[23:16] : 8'h0;
        base.message_id    = hdr_valid ? hs_eff[15:0]  : 16'h0;
        base.token_length  = hdr_valid ? hs_eff[27:24] : 4'd0;

        emit_res               = base;
        emit_res.kind          = e_kind;
        emit_res.option_number = e_num;
        emit_res.option_length = e_len;
        emit_res.out_byte      = e_byte;
        emit_res.last          = !has_term;

        term_res      = base;
        term_res.kind = term_fail ? EV_ERROR : EV_COMPLETE;
        term_res.last = 1'b1;

        pair.count = {1'b0, e_valid} + {1'b0, has_term};
        pair.res0  = e_valid ? emit_res : term_res;
        pair.res1  = term_res;
    end

endmodule

### sv/cmsp_result_fifo.sv
// Result queue that takes zero, one or two result items per cycle and hands out one.
module cmsp_result_fifo #(
    parameter int unsigned Depth = cmsp_pkg::CMSP_FIFO_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  cmsp_pkg::result_pair_t wr_pair,
    input  logic                   rd_ready,
    output logic                   rd_valid,
    output cmsp_pkg::result_t      rd_data,
    output logic                   room_two
);
    import cmsp_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    result_t        mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      push;
    logic            pop;

    assign push     = wr_en ? wr_pair.count : 2'd0;
    assign pop      = rd_valid && rd_ready;
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign room_two = (count_reg <= CntW'(Depth - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push == 2'd1) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end else if (push == 2'd2) begin
            wr_ptr_next = ptr_inc(ptr_inc(wr_ptr_reg));
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            mem[wr_ptr_reg] <= wr_pair.res0;
        end
        if (push == 2'd2) begin
            mem[ptr_inc(wr_ptr_reg)] <= wr_pair.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/coap_message_stream_parser_unit.sv
// CoAP datagram byte parser: header, token, option and payload events with syntax checks.
//
// One datagram byte enters per transfer on the s_ side, with s_tlast on its final byte.
// Each byte is registered, decoded combinationally against the parser state, and its
// result items are written to a result queue of FifoDepth entries that drives the m_ side.
// Bytes are taken back to back at one per cycle while the queue has room for two results.
// The first result of a byte is offered on the m_ side once the byte has passed the input
// register and the result is in the queue. A byte that yields two results (any other
// event followed by a completion or error event) needs two output transfers, and the
// input is stalled only when the queue has fewer than two free entries. After a syntax
// error, the rest of the datagram is swallowed without results.
`include "assert_macros.svh"

module coap_message_stream_parser_unit #(
    parameter int unsigned FifoDepth = cmsp_pkg::CMSP_FIFO_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmsp_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] msg_type, [9:2] msg_code, [25:10] message_id, [29:26] token_length,
    // [45:30] option_number, [61:46] option_length, [69:62] out_byte, [71:70] zero
    output logic [cmsp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [cmsp_pkg::M_TUSER_W-1:0]  m_tuser,   // [2:0] event_kind
    output logic                            m_tlast    // last_of_run
);
    import cmsp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_pair_t pair;
    result_t      head;
    logic         room_two;
    logic         proceed;

    assign proceed       = in_valid_reg && room_two;
    assign s_tready      = !in_valid_reg || proceed;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= PARSE_STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (proceed) begin
                state_reg <= state_next;
            end
        end
    end

    cmsp_decoder u_decoder (
        .cur       (state_reg),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .pair      (pair)
    );

    cmsp_result_fifo #(
        .Depth (FifoDepth)
    ) u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (proceed),
        .wr_pair  (pair),
        .rd_ready (m_tready),
        .rd_valid (m_tvalid),
        .rd_data  (head),
        .room_two (room_two)
    );

    assign m_tdata = {2'b00, head.out_byte, head.option_length, head.option_number,
                      head.token_length, head.message_id, head.msg_code, head.msg_type};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `CMSP_ASSERT_IMP(a_discard_silent, aclk, aresetn,
        proceed && state_reg.discarding, pair.count == 2'd0)
    `CMSP_ASSERT_IMP(a_pair_ends_run, aclk, aresetn, proceed && pair.count == 2'd2,
        pair.res1.kind == EV_COMPLETE || pair.res1.kind == EV_ERROR)
    `CMSP_ASSERT_IMP(a_single_is_last, aclk, aresetn,
        proceed && pair.count == 2'd1, pair.res0.last)
    `CMSP_ASSERT_NEXT(a_result_shows, aclk, aresetn,
        proceed && pair.count != 2'd0, m_tvalid)

endmodule

### tb/sv/tb_coap_message_stream_parser_unit.sv
// Self-checking testbench for the CoAP message stream parser with a built-in event predictor.
`timescale 1ns / 1ps

module tb_coap_message_stream_parser_unit;

    import cmsp_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_BYTES   = 1950;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int REPORT_LINES   = 40;

    localparam logic [1:0] MT_CON = 2'd0;
    localparam logic [1:0] MT_NON = 2'd1;
    localparam logic [1:0] MT_ACK = 2'd2;
    localparam logic [1:0] MT_RST = 2'd3;

    localparam int OPT_IF_MATCH       = 1;
    localparam int OPT_URI_HOST       = 3;
    localparam int OPT_ETAG           = 4;
    localparam int OPT_IF_NONE_MATCH  = 5;
    localparam int OPT_OBSERVE        = 6;
    localparam int OPT_URI_PORT       = 7;
    localparam int OPT_LOCATION_PATH  = 8;
    localparam int OPT_URI_PATH       = 11;
    localparam int OPT_CONTENT_FORMAT = 12;
    localparam int OPT_MAX_AGE        = 14;
    localparam int OPT_URI_QUERY      = 15;
    localparam int OPT_ACCEPT         = 17;
    localparam int OPT_LOCATION_QUERY = 20;
    localparam int OPT_PROXY_URI      = 35;
    localparam int OPT_PROXY_SCHEME   = 39;
    localparam int OPT_SIZE1          = 60;
    localparam int OPT_CHECKED_MAX    = 255;

    localparam logic [3:0] NIB_EXT8     = 4'd13;
    localparam logic [3:0] NIB_EXT16    = 4'd14;
    localparam logic [3:0] NIB_RESERVED = 4'd15;
    localparam int         EXT8_BASE    = 13;
    localparam int         EXT16_BASE   = 269;
    localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } dgram_byte_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    coap_message_stream_parser_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    dgram_byte_t datagram_bytes[$];
    result_t     predicted_events[$];
    logic [7:0]  frame_bytes[$];

    int error_count  = 0;
    int result_count = 0;
    int cycle_count  = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int stall_left   = 0;
    rx_mode_t stall_mode = RX_STEADY;

    // Parser state as predicted from the accepted byte stream.
    phase_t      ph;
    logic [31:0] hdr_word;
    logic [1:0]  hdr_count;
    logic [3:0]  token_left;
    logic [15:0] option_sum;
    logic [15:0] delta_acc;
    logic [15:0] length_acc;
    logic [15:0] value_left;
    logic [1:0]  ext_left;
    logic        dropping;
    result_t     step_events[2];
    int          step_count;

    function automatic void clear_state();
        ph         = PH_IDLE;
        hdr_word   = 32'd0;
        hdr_count  = 2'd0;
        token_left = 4'd0;
        option_sum = 16'd0;
        delta_acc  = 16'd0;
        length_acc = 16'd0;
        value_left = 16'd0;
        ext_left   = 2'd0;
        dropping   = 1'b0;
    endfunction

    function automatic void push_event(event_kind_t kind, logic [15:0] num, logic [15:0] len,
                                       logic [7:0] data);
        result_t ev;
        logic    hv;
        hv = (ph != PH_IDLE);
        if (step_count >= 2) return;
        ev.kind          = kind;
        ev.msg_type      = hv ? hdr_word[29:28] : 2'd0;
        ev.msg_code      = hv ? hdr_word[23:16] : 8'd0;
        ev.message_id    = hv ? hdr_word[15:0] : 16'd0;
        ev.token_length  = hv ? hdr_word[27:24] : 4'd0;
        ev.option_number = num;
        ev.option_length = len;
        ev.out_byte      = data;
        ev.last          = 1'b0;
        step_events[step_count] = ev;
        step_count++;
    endfunction

    function automatic void finish_ok();
        push_event(EV_COMPLETE, 16'd0, 16'd0, 8'd0);
        clear_state();
    endfunction

    function automatic void flag_error(logic last);
        push_event(EV_ERROR, 16'd0, 16'd0, 8'd0);
        clear_state();
        if (!last) dropping = 1'b1;
    endfunction

    function automatic bit type_code_ok(logic [1:0] t, logic [7:0] c);
        if (c == 8'd0) return t == MT_ACK || t == MT_RST;
        if (c >= 8'd1 && c <= 8'd4) return t == MT_CON || t == MT_NON;
        if ((c >= 8'd65 && c <= 8'd69) || (c >= 8'd128 && c <= 8'd134) || c == 8'd140 ||
            c == 8'd141 || c == 8'd143 || (c >= 8'd160 && c <= 8'd165))
            return t != MT_RST;
        return 1'b0;
    endfunction

    function automatic bit option_ok(logic [15:0] num, logic [15:0] delta, logic [15:0] len);
        bit rep;
        rep = (delta == 16'd0);
        if (num > OPT_CHECKED_MAX) return 1'b1;
        case (num)
            OPT_IF_NONE_MATCH: return len == 0 && !rep;
            OPT_ETAG:          return len != 0 && len <= 8;
            OPT_IF_MATCH:      return len <= 8;
            OPT_URI_PORT, OPT_CONTENT_FORMAT, OPT_ACCEPT: return len <= 2 && !rep;
            OPT_OBSERVE:       return len <= 3 && !rep;
            OPT_MAX_AGE, OPT_SIZE1: return len <= 4 && !rep;
            OPT_URI_HOST, OPT_PROXY_SCHEME: return len != 0 && len <= 255 && !rep;
            OPT_LOCATION_PATH, OPT_URI_PATH, OPT_URI_QUERY, OPT_LOCATION_QUERY:
                return len <= 255;
            OPT_PROXY_URI:     return len != 0 && len <= 1034 && !rep;
            default:           return 1'b0;
        endcase
    endfunction

    function automatic void finish_option(logic last);
        logic [15:0] num;
        num = option_sum + delta_acc;
        if (!option_ok(num, delta_acc, length_acc)) begin
            flag_error(last);
        end else begin
            option_sum = num;
            push_event(EV_OPTION, num, length_acc, 8'd0);
            if (length_acc == 16'd0) begin
                ph = PH_OPTHDR;
                if (last) finish_ok();
            end else begin
                value_left = length_acc;
                ph = PH_VALUE;
                if (last) flag_error(1'b1);
            end
        end
    endfunction

    function automatic void start_length(logic last);
        logic [3:0] nib;
        nib = length_acc[3:0];
        if (nib < NIB_EXT8) begin
            length_acc = {12'd0, nib};
            finish_option(last);
        end else if (nib == NIB_RESERVED) begin
            flag_error(last);
        end else begin
            length_acc = (nib == NIB_EXT8) ? 16'(EXT8_BASE) : 16'(EXT16_BASE);
            ext_left   = (nib == NIB_EXT8) ? 2'd1 : 2'd2;
            ph = PH_LEN_EXT;
            if (last) flag_error(1'b1);
        end
    endfunction

    function automatic void option_header(logic [7:0] b, logic last);
        if (b == PAYLOAD_MARKER) begin
            ph = PH_PAYLOAD;
            if (last) finish_ok();
        end else if (b[7:4] == NIB_RESERVED) begin
            flag_error(last);
        end else begin
            length_acc = {12'd0, b[3:0]};
            if (b[7:4] < NIB_EXT8) begin
                delta_acc = {12'd0, b[7:4]};
                start_length(last);
            end else begin
                delta_acc = (b[7:4] == NIB_EXT8) ? 16'(EXT8_BASE) : 16'(EXT16_BASE);
                ext_left  = (b[7:4] == NIB_EXT8) ? 2'd1 : 2'd2;
                ph = PH_DELTA_EXT;
                if (last) flag_error(1'b1);
            end
        end
    endfunction

    function automatic logic [15:0] ext_add(logic [15:0] work, logic [7:0] b);
        logic [15:0] addend;
        addend   = (ext_left == 2'd2) ? {b, 8'd0} : {8'd0, b};
        ext_left = ext_left - 2'd1;
        return work + addend;
    endfunction

    function automatic void header_byte(logic [7:0] b, logic last);
        hdr_word = {hdr_word[23:0], b};
        if (hdr_count < 2'd3) begin
            hdr_count = hdr_count + 2'd1;
            if (last) flag_error(1'b1);
        end else begin
            hdr_count = 2'd0;
            if (hdr_word[31:30] != 2'd1 || !type_code_ok(hdr_word[29:28], hdr_word[23:16]) ||
                hdr_word[27:24] > 4'd8) begin
                flag_error(last);
            end else begin
                token_left = hdr_word[27:24];
                option_sum = 16'd0;
                ph = (token_left != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                push_event(EV_HEADER, 16'd0, 16'd0, 8'd0);
                if (last) begin
                    if (token_left != 4'd0) flag_error(1'b1);
                    else finish_ok();
                end
            end
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        step_count = 0;
        if (dropping) begin
            if (last) clear_state();
        end else begin
            case (ph)
                PH_IDLE: header_byte(b, last);
                PH_TOKEN: begin
                    push_event(EV_TOKEN, 16'd0, 16'd0, b);
                    token_left = token_left - 4'd1;
                    if (token_left == 4'd0) begin
                        ph = PH_OPTHDR;
                        if (last) finish_ok();
                    end else if (last) begin
                        flag_error(1'b1);
                    end
                end
                PH_OPTHDR: option_header(b, last);
                PH_DELTA_EXT: begin
                    delta_acc = ext_add(delta_acc, b);
                    if (ext_left == 2'd0) start_length(last);
                    else if (last) flag_error(1'b1);
                end
                PH_LEN_EXT: begin
                    length_acc = ext_add(length_acc, b);
                    if (ext_left == 2'd0) finish_option(last);
                    else if (last) flag_error(1'b1);
                end
                PH_VALUE: begin
                    push_event(EV_OPT_BYTE, option_sum, length_acc, b);
                    value_left = value_left - 16'd1;
                    if (value_left == 16'd0) begin
                        ph = PH_OPTHDR;
                        if (last) finish_ok();
                    end else if (last) begin
                        flag_error(1'b1);
                    end
                end
                PH_PAYLOAD: begin
                    push_event(EV_PAYLOAD, 16'd0, 16'd0, b);
                    if (last) finish_ok();
                end
                default: flag_error(last);
            endcase
        end
        if (step_count > 0) step_events[step_count - 1].last = 1'b1;
        for (int i = 0; i < step_count; i++) predicted_events.push_back(step_events[i]);
    endfunction

    // Stimulus generation.
    function automatic int known_option(int idx);
        case (idx)
            0:  return OPT_IF_MATCH;
            1:  return OPT_URI_HOST;
            2:  return OPT_ETAG;
            3:  return OPT_IF_NONE_MATCH;
            4:  return OPT_OBSERVE;
            5:  return OPT_URI_PORT;
            6:  return OPT_LOCATION_PATH;
            7:  return OPT_URI_PATH;
            8:  return OPT_CONTENT_FORMAT;
            9:  return OPT_MAX_AGE;
            10: return OPT_URI_QUERY;
            11: return OPT_ACCEPT;
            12: return OPT_LOCATION_QUERY;
            13: return OPT_PROXY_URI;
            14: return OPT_PROXY_SCHEME;
            default: return OPT_SIZE1;
        endcase
    endfunction

    task automatic option_len_limits(input logic [15:0] num, output int lo, output int hi,
                                     output bit rep);
        lo = 0;
        hi = 65535;
        rep = 1'b1;
        case (num)
            OPT_IF_NONE_MATCH: begin hi = 0; rep = 1'b0; end
            OPT_ETAG:          begin lo = 1; hi = 8; end
            OPT_IF_MATCH:      hi = 8;
            OPT_URI_PORT, OPT_CONTENT_FORMAT, OPT_ACCEPT: begin hi = 2; rep = 1'b0; end
            OPT_OBSERVE:       begin hi = 3; rep = 1'b0; end
            OPT_MAX_AGE, OPT_SIZE1: begin hi = 4; rep = 1'b0; end
            OPT_URI_HOST, OPT_PROXY_SCHEME: begin lo = 1; hi = 255; rep = 1'b0; end
            OPT_LOCATION_PATH, OPT_URI_PATH, OPT_URI_QUERY, OPT_LOCATION_QUERY: hi = 255;
            OPT_PROXY_URI:     begin lo = 1; hi = 1034; rep = 1'b0; end
            default: ;
        endcase
    endtask

    // Values are sometimes encoded through the 16-bit extension with wrap-around.
    task automatic encode_field(input logic [15:0] v, output logic [3:0] nib,
                                output logic [15:0] ext);
        if ($urandom_range(0, 11) == 0 || v >= EXT16_BASE) begin
            nib = NIB_EXT16;
            ext = 16'(v - EXT16_BASE);
        end else if (v >= EXT8_BASE) begin
            nib = NIB_EXT8;
            ext = 16'(v - EXT8_BASE);
        end else begin
            nib = v[3:0];
            ext = 16'd0;
        end
    endtask

    task automatic push_ext(logic [3:0] nib, logic [15:0] ext);
        if (nib == NIB_EXT8) begin
            frame_bytes.push_back(ext[7:0]);
        end else if (nib == NIB_EXT16) begin
            frame_bytes.push_back(ext[15:8]);
            frame_bytes.push_back(ext[7:0]);
        end
    endtask

    task automatic add_option(logic [15:0] delta, logic [15:0] len);
        logic [3:0]  dn, ln;
        logic [15:0] dx, lx;
        encode_field(delta, dn, dx);
        encode_field(len, ln, lx);
        frame_bytes.push_back({dn, ln});
        push_ext(dn, dx);
        push_ext(ln, lx);
    endtask

    task automatic pick_type_code(output logic [1:0] mtype, output logic [7:0] code);
        mtype = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0: begin
                code  = 8'd0;
                mtype = $urandom_range(0, 1) ? MT_ACK : MT_RST;
            end
            1: begin
                code  = 8'($urandom_range(1, 4));
                mtype = $urandom_range(0, 1) ? MT_CON : MT_NON;
            end
            2: code = 8'($urandom_range(65, 69));
            3: code = 8'($urandom_range(128, 134));
            4: code = ($urandom_range(0, 2) == 0) ? 8'd140 :
                      ($urandom_range(0, 1) ? 8'd141 : 8'd143);
            default: code = 8'($urandom_range(160, 165));
        endcase
    endtask

    task automatic build_message(bit sloppy);
        logic [1:0]  mtype;
        logic [7:0]  code;
        logic [3:0]  tkl;
        logic [15:0] sum, num, len;
        int          lo, hi, span;
        bit          rep;
        pick_type_code(mtype, code);
        tkl = 4'($urandom_range(0, 8));
        frame_bytes.push_back({2'b01, mtype, tkl});
        frame_bytes.push_back(code);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (tkl) frame_bytes.push_back(8'($urandom_range(0, 255)));
        sum = 16'd0;
        repeat ($urandom_range(0, 5)) begin
            num = 16'(known_option($urandom_range(0, 15)));
            option_len_limits(num, lo, hi, rep);
            if (sloppy && $urandom_range(0, 2) == 0) begin
                num = 16'(sum + $urandom_range(0, 40));
                lo = 0;
                hi = 10;
            end else if (sum > 16'd60 || num < sum || (num == sum && !rep) ||
                         $urandom_range(0, 3) == 0) begin
                if (sum <= OPT_CHECKED_MAX)
                    num = 16'(OPT_CHECKED_MAX + 1 + $urandom_range(0, 3000));
                else if ($urandom_range(0, 7) == 0) num = 16'(sum + $urandom_range(0, 65535));
                else num = 16'(sum + $urandom_range(0, 3000));
                option_len_limits(num, lo, hi, rep);
            end
            span = (hi - lo > 12) ? 12 : hi - lo;
            if ($urandom_range(0, 14) == 0) span = (hi - lo > 300) ? 300 : hi - lo;
            len = 16'(lo + $urandom_range(0, span));
            if (hi > 12 && hi <= 1034 && $urandom_range(0, 29) == 0) len = 16'(hi);
            add_option(num - sum, len);
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            sum = num;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                frame_bytes.push_back(PAYLOAD_MARKER);
                repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            5: frame_bytes.push_back(PAYLOAD_MARKER);
            default: ;
        endcase
    endtask

    task automatic send_frame();
        dgram_byte_t item;
        foreach (frame_bytes[i]) begin
            item.data = frame_bytes[i];
            item.last = (i == frame_bytes.size() - 1);
            datagram_bytes.push_back(item);
        end
        frame_bytes.delete();
    endtask

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= REPORT_LINES) $display("mismatch at result %0d: %s", result_count, msg);
    endtask

    task automatic compare_field(string field, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    initial clear_state();

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin : byte_driver
        dgram_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (datagram_bytes.size() != 0) begin
                    nxt = datagram_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : ready_pattern
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 200);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (cycle_count % 5) != 2;
            endcase
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_events.size() == 0) begin
                report_mismatch("result transfer with nothing predicted");
            end else begin
                want = predicted_events.pop_front();
                compare_field("event_kind", m_tuser, want.kind);
                compare_field("msg_type", m_tdata[1:0], want.msg_type);
                compare_field("msg_code", m_tdata[9:2], want.msg_code);
                compare_field("message_id", m_tdata[25:10], want.message_id);
                compare_field("token_length", m_tdata[29:26], want.token_length);
                compare_field("option_number", m_tdata[45:30], want.option_number);
                compare_field("option_length", m_tdata[61:46], want.option_length);
                compare_field("out_byte", m_tdata[69:62], want.out_byte);
                compare_field("tdata padding", m_tdata[71:70], 16'd0);
                compare_field("last_of_run", m_tlast, want.last);
            end
            result_count++;
        end
    end

    initial begin : stimulus
        int kind_sel;
        int cut;
        int target;
        // Header with empty payload marker on the last byte, then a short header.
        frame_bytes = {8'h40, 8'h01, 8'h12, 8'h34, 8'hFF};
        send_frame();
        frame_bytes = {8'h50, 8'h45};
        send_frame();
        // Bad version; the trailing byte is swallowed.
        frame_bytes = {8'h80, 8'h01, 8'h00, 8'h00, 8'h00};
        send_frame();
        // Truncated token.
        frame_bytes = {8'h42, 8'h01, 8'h00, 8'h01, 8'hAA};
        send_frame();
        // Reserved delta nibble, then reserved length nibble.
        frame_bytes = {8'h40, 8'h01, 8'h00, 8'h02, 8'hF0};
        send_frame();
        frame_bytes = {8'h40, 8'h01, 8'hFF, 8'hFF, 8'h1F};
        send_frame();

        target = datagram_bytes.size() + RANDOM_BYTES;
        while (datagram_bytes.size() < target) begin
            kind_sel = $urandom_range(0, 19);
            if (kind_sel == 19)
                repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            else
                build_message(kind_sel == 13 || kind_sel == 14);
            if ((kind_sel == 15 || kind_sel == 16) && frame_bytes.size() > 1) begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            if (kind_sel == 17 || kind_sel == 18)
                frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            send_frame();
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (datagram_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (predicted_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
